// ===== design/linear_interp_stereo_resampler_macros.svh =====
// Assertion helpers shared by the resampler top level.
`ifndef LINEAR_INTERP_STEREO_RESAMPLER_MACROS_SVH
`define LINEAR_INTERP_STEREO_RESAMPLER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LISR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define LISR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/lisr_pkg.sv =====
package lisr_pkg;

  localparam int SAMPLE_BITS     = 24;
  localparam int PHASE_FRAC_BITS = 16;
  localparam int MAX_RUN         = 16;
  localparam int RATIO_BITS      = 19;
  localparam int CNT_BITS        = $clog2(MAX_RUN);
  localparam int TDATA_BITS      = ((2 * SAMPLE_BITS + 7) / 8) * 8;
  // Difference of two samples, one bit wider than a sample.
  localparam int DIFF_BITS       = SAMPLE_BITS + 1;
  // Difference times a phase below 1.0 (PHASE_FRAC_BITS + 1 bits signed).
  localparam int PROD_BITS       = DIFF_BITS + PHASE_FRAC_BITS + 1;
  localparam int STEP_BITS       = PROD_BITS - PHASE_FRAC_BITS;
  localparam int SUM_BITS        = STEP_BITS + 1;

  localparam logic [RATIO_BITS-1:0] PHASE_ONE   = RATIO_BITS'(1) << PHASE_FRAC_BITS;
  localparam logic [RATIO_BITS-1:0] RATIO_RESET = PHASE_ONE;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic in_load;    // capture the accepted frame for the run or passthrough
    logic prime;      // first frame: hold it and mark primed
    logic skip;       // phase at or above 1.0: drop 1.0 and hold the frame
    logic run_start;  // form differences and clear the run counter
    logic mul_en;     // register the two products
    logic out_load;   // load an interpolated result into the output register
    logic pass_load;  // load the captured frame unchanged into the output register
  } lisr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pass_mode;     // ratio equals 1.0
    logic primed;        // a frame is held
    logic phase_ge_one;  // no interpolation is due for the next frame
    logic run_end;       // the result being formed is the last of its frame
    logic out_free;      // output register is empty or drains this cycle
  } lisr_stat_t;

  function automatic sample_t sat_sample(input logic signed [SUM_BITS-1:0] v);
    logic signed [SUM_BITS-1:0] hi;
    logic signed [SUM_BITS-1:0] lo;
    hi = SUM_BITS'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
    lo = -hi - SUM_BITS'(1);
    if (v > hi) begin
      return sample_t'(hi);
    end else if (v < lo) begin
      return sample_t'(lo);
    end
    return sample_t'(v);
  endfunction

endpackage

// ===== design/lisr_ctrl.sv =====
module lisr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  lisr_pkg::lisr_stat_t stat,
  output lisr_pkg::lisr_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIFF = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_SUM  = 3'd3;
  localparam logic [2:0] ST_PASS = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (stat.pass_mode) begin
            cmd.in_load = 1'b1;
            state_next  = ST_PASS;
          end else if (!stat.primed) begin
            cmd.prime = 1'b1;
          end else if (stat.phase_ge_one) begin
            cmd.skip = 1'b1;
          end else begin
            cmd.in_load = 1'b1;
            state_next  = ST_DIFF;
          end
        end
      end
      ST_DIFF: begin
        cmd.run_start = 1'b1;
        state_next    = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = stat.run_end ? ST_IDLE : ST_MUL;
        end
      end
      ST_PASS: begin
        if (stat.out_free) begin
          cmd.pass_load = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== design/lisr_datapath.sv =====
module lisr_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [lisr_pkg::TDATA_BITS-1:0]     s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [lisr_pkg::TDATA_BITS-1:0]     m_tdata,
  output logic                                m_tlast,
  input  logic                                cfg_valid,
  input  logic [lisr_pkg::RATIO_BITS-1:0]     cfg_data,
  input  lisr_pkg::lisr_cmd_t                 cmd,
  output lisr_pkg::lisr_stat_t                stat
);

  localparam int SB = lisr_pkg::SAMPLE_BITS;
  localparam int RB = lisr_pkg::RATIO_BITS;
  localparam int PF = lisr_pkg::PHASE_FRAC_BITS;
  localparam int PB = lisr_pkg::PROD_BITS;
  localparam int CB = lisr_pkg::CNT_BITS;

  logic [RB-1:0]                    ratio;
  logic [RB-1:0]                    phase;
  logic                             primed;
  lisr_pkg::sample_t                held_l;
  lisr_pkg::sample_t                held_r;
  lisr_pkg::sample_t                new_l;
  lisr_pkg::sample_t                new_r;
  logic signed [lisr_pkg::DIFF_BITS-1:0] diff_l;
  logic signed [lisr_pkg::DIFF_BITS-1:0] diff_r;
  logic signed [PB-1:0]             prod_l;
  logic signed [PB-1:0]             prod_r;
  logic [CB-1:0]                    cnt;
  lisr_pkg::sample_t                out_l;
  lisr_pkg::sample_t                out_r;

  lisr_pkg::sample_t                s_l;
  lisr_pkg::sample_t                s_r;
  logic [RB:0]                      phase_sum;
  logic [RB-1:0]                    phase_end;
  logic signed [PB-1:0]             mul_a_l;
  logic signed [PB-1:0]             mul_a_r;
  logic signed [PB-1:0]             mul_b;
  logic signed [lisr_pkg::SUM_BITS-1:0] sum_l;
  logic signed [lisr_pkg::SUM_BITS-1:0] sum_r;

  assign s_l = lisr_pkg::sample_t'(s_tdata[SB-1:0]);
  assign s_r = lisr_pkg::sample_t'(s_tdata[2*SB-1:SB]);

  assign phase_sum = {1'b0, phase} + {1'b0, ratio};
  assign phase_end = (phase_sum >= {1'b0, lisr_pkg::PHASE_ONE})
                   ? RB'(phase_sum - {1'b0, lisr_pkg::PHASE_ONE}) : '0;

  // Phase is below 1.0 during a run, so its fraction bits are the whole factor.
  assign mul_a_l = PB'(diff_l);
  assign mul_a_r = PB'(diff_r);
  assign mul_b   = PB'($signed({1'b0, phase[PF-1:0]}));

  // Arithmetic shift of the product floors toward minus infinity.
  assign sum_l = lisr_pkg::SUM_BITS'(held_l)
               + lisr_pkg::SUM_BITS'($signed(prod_l[PB-1:PF]));
  assign sum_r = lisr_pkg::SUM_BITS'(held_r)
               + lisr_pkg::SUM_BITS'($signed(prod_r[PB-1:PF]));

  always_comb begin
    stat.pass_mode    = (ratio == lisr_pkg::PHASE_ONE);
    stat.primed       = primed;
    stat.phase_ge_one = (phase >= lisr_pkg::PHASE_ONE);
    stat.run_end      = (phase_sum >= {1'b0, lisr_pkg::PHASE_ONE})
                     || (cnt == CB'(lisr_pkg::MAX_RUN - 1));
    stat.out_free     = !m_tvalid || m_tready;
  end

  assign m_tdata = lisr_pkg::TDATA_BITS'({out_r, out_l});

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      ratio    <= lisr_pkg::RATIO_RESET;
      phase    <= '0;
      primed   <= 1'b0;
      held_l   <= '0;
      held_r   <= '0;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        ratio <= cfg_data;
      end
      if (cmd.prime) begin
        primed <= 1'b1;
        held_l <= s_l;
        held_r <= s_r;
      end
      if (cmd.skip) begin
        phase  <= phase - lisr_pkg::PHASE_ONE;
        held_l <= s_l;
        held_r <= s_r;
      end
      if (cmd.run_start) begin
        cnt <= '0;
      end
      if (cmd.out_load) begin
        cnt <= cnt + CB'(1);
        if (stat.run_end) begin
          phase  <= phase_end;
          held_l <= new_l;
          held_r <= new_r;
        end else begin
          phase <= phase_sum[RB-1:0];
        end
      end
      if (cmd.out_load || cmd.pass_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      new_l <= s_l;
      new_r <= s_r;
    end
    if (cmd.run_start) begin
      diff_l <= lisr_pkg::DIFF_BITS'(new_l) - lisr_pkg::DIFF_BITS'(held_l);
      diff_r <= lisr_pkg::DIFF_BITS'(new_r) - lisr_pkg::DIFF_BITS'(held_r);
    end
    if (cmd.mul_en) begin
      prod_l <= mul_a_l * mul_b;
      prod_r <= mul_a_r * mul_b;
    end
    if (cmd.out_load) begin
      out_l   <= lisr_pkg::sat_sample(sum_l);
      out_r   <= lisr_pkg::sat_sample(sum_r);
      m_tlast <= stat.run_end;
    end else if (cmd.pass_load) begin
      out_l   <= new_l;
      out_r   <= new_r;
      m_tlast <= 1'b1;
    end
  end

endmodule

// ===== design/linear_interp_stereo_resampler.sv =====
// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid/s_tready    s_tdata: in_left, in_right
// m_*       out        m_tvalid/m_tready    m_tdata: out_left, out_right; m_tlast: run_last
// cfg_*     in         cfg_valid/cfg_ready  cfg_data: rate_ratio
//
// An interpolating frame gives n results (n at most 16): it is accepted, its differences are
// formed, then each result takes a multiply step and an add-and-saturate step through the
// single pair of multipliers. A passthrough frame is accepted, then loaded unchanged into
// the output register; a priming frame and a frame that only drops the phase end on acceptance.
// Reset (rst, synchronous, active high) restores a ratio of 1.0, clears phase, held frame
// and primed flag, and empties the output register.
// A stalled output holds the run in place; the next frame is taken once the run is over.

module linear_interp_stereo_resampler (
  input  logic                            clk,
  input  logic                            rst,
  // Source frames.
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [lisr_pkg::TDATA_BITS-1:0] s_tdata,   // [23:0] in_left, [47:24] in_right
  // Output frames.
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [lisr_pkg::TDATA_BITS-1:0] m_tdata,   // [23:0] out_left, [47:24] out_right
  output logic                            m_tlast,   // run_last
  // Ratio register write.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lisr_pkg::RATIO_BITS-1:0] cfg_data
);

  lisr_pkg::lisr_cmd_t  cmd;
  lisr_pkg::lisr_stat_t stat;

  // The ratio register accepts a write in any cycle.
  assign cfg_ready = 1'b1;

  // The controller sequences each frame: prime, phase drop, passthrough, or a run of
  // alternating multiply and add steps, one result per multiply and add step.
  lisr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the ratio, phase, held frame, the product pipeline and the
  // output register.
  lisr_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat)
  );

`include "linear_interp_stereo_resampler_macros.svh"

  // While a frame may be accepted, no result is being formed.
  `LISR_ASSERT_NOW(a_idle_no_load, s_tready, !(cmd.out_load || cmd.pass_load), "load while idle")
  // A waiting result is never overwritten.
  `LISR_ASSERT_NOW(a_no_overwrite, m_tvalid && !m_tready, !(cmd.out_load || cmd.pass_load),
                   "output overwritten")
  // The last result of a run returns the block to accepting frames.
  `LISR_ASSERT_NEXT(a_run_end_idle, cmd.out_load && stat.run_end, s_tready && m_tlast,
                    "run did not close")
  // A passthrough result is a run of one.
  `LISR_ASSERT_NEXT(a_pass_last, cmd.pass_load, m_tvalid && m_tlast, "passthrough not last")

endmodule
